>>> sv/assert_macros.svh
// Assertion macros shared by the RTL modules.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define FCTAG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be seen.
`define FCTAG_ASSERT_NEVER(label, expr, msg) \
  `FCTAG_ASSERT(label, !(expr), msg)

`endif

>>> sv/fctag_pkg.sv
// Package for the floor/ceiling texel address generator.
// Holds geometry constants, register codes and sequencer types; no dependencies.
package fctag_pkg;

  localparam int LinePitch = 320;   // framebuffer words per line
  localparam int MapDim    = 64;    // map tiles per side, power of two
  localparam int TexDim    = 64;    // texels per side, power of two
  localparam int MaxWidth  = 1024;  // widest view row

  localparam int DenScale  = 175;   // extra divisor of the texture step
  localparam int DistShift = 5;
  localparam int TexShift  = 8;
  localparam int WallShift = 3;

  localparam int DivBits  = 32;
  localparam int DivCntW  = $clog2(DivBits);
  localparam logic [DivCntW-1:0] DivLast = DivCntW'(DivBits - 1);

  typedef enum logic [2:0] {
    REG_VIEW_X,
    REG_VIEW_Y,
    REG_VIEW_COS,
    REG_VIEW_SIN,
    REG_HEIGHT_NUM,
    REG_VIEW_WIDTH,
    REG_VIEW_HEIGHT,
    REG_MIN_WALL
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_HN,
    ST_MUL,
    ST_POST,
    ST_DIV_STEP,
    ST_TEX,
    ST_EMIT
  } state_e;

  typedef enum logic [2:0] {
    OP_DEN,
    OP_GU,
    OP_GV,
    OP_USTEP,
    OP_VSTEP,
    OP_UACC,
    OP_VACC
  } mul_op_e;

endpackage

>>> sv/floor_ceiling_texel_address_gen.sv
// Floor/ceiling texel address generator, top level.
// Uses fctag_pkg and assert_macros.svh.

// One pixel per beat, rows in order, left to right. A pixel that is not the
// first of its row is accepted whenever the output register is empty or being
// drained, so such pixels stream at one per cycle. The first pixel of a row
// (column counter at zero) starts the row setup and holds s_axis_tready low
// during it: a 32-step restoring divide of the height numerator by row+1,
// one pass of the shared 32x18 multiplier for width*175, a second 32-step
// divide for the texture step, then six multiply/post pairs for start u/v
// and steps. The setup runs on the shared divider and the single multiplier.
// Results leave through a registered master port; tlast marks the last
// column of a row, tuser is the draw flag. Configuration writes are always
// ready and are meant for idle periods; u/v and steps pick up new values at
// the next row start.
module floor_ceiling_texel_address_gen (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  fctag_pkg::cfg_reg_e cfg_addr_i,
  input  logic [31:0]         cfg_data_i,
  // pixel input
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [31:0]         s_axis_tdata,  // [8:0] row, [24:9] column_wall_height
  // result output
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [63:0]         m_axis_tdata,  // [5:0] map_x, [11:6] map_y,
                                             // [23:12] texel_offset,
                                             // [43:24] ceiling_address,
                                             // [63:44] floor_address
  output logic [0:0]          m_axis_tuser,  // [0] draw
  output logic                m_axis_tlast   // row_end
);
  import fctag_pkg::*;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [21:0]        view_x_q, view_y_q;
  logic signed [17:0] view_cos_q, view_sin_q;
  logic [30:0]        hnum_q;
  logic [10:0]        view_width_q, view_height_q;
  logic [15:0]        min_wall_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      view_x_q      <= '0;
      view_y_q      <= '0;
      view_cos_q    <= 18'sd65536;
      view_sin_q    <= '0;
      hnum_q        <= '0;
      view_width_q  <= 11'd320;
      view_height_q <= 11'd160;
      min_wall_q    <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_addr_i)
        REG_VIEW_X:      view_x_q      <= cfg_data_i[21:0];
        REG_VIEW_Y:      view_y_q      <= cfg_data_i[21:0];
        REG_VIEW_COS:    view_cos_q    <= cfg_data_i[17:0];
        REG_VIEW_SIN:    view_sin_q    <= cfg_data_i[17:0];
        REG_HEIGHT_NUM:  hnum_q        <= cfg_data_i[30:0];
        REG_VIEW_WIDTH:  view_width_q  <= cfg_data_i[10:0];
        REG_VIEW_HEIGHT: view_height_q <= cfg_data_i[10:0];
        REG_MIN_WALL:    min_wall_q    <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Derived view geometry
  // ---------------------------------------------------------------------
  logic [10:0] width_eff;
  logic [9:0]  half_h;    // horizon row count
  logic [9:0]  half_w;    // start offset in pixels

  always_comb begin
    if (view_width_q == 11'd0)                  width_eff = 11'd1;
    else if (view_width_q > 11'(MaxWidth))      width_eff = 11'(MaxWidth);
    else                                        width_eff = view_width_q;
  end
  assign half_h = view_height_q[10:1];
  assign half_w = width_eff[10:1];

  // ---------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------
  state_e  state_q, state_d;
  mul_op_e op_q;

  logic [9:0]  column_count_q;
  logic [31:0] u_acc_q, v_acc_q, u_step_q, v_step_q;
  logic [8:0]  row_q;
  logic [15:0] wall_q;
  logic [31:0] dist_q, tex_q;
  logic        neg_q;

  // shared divider: dividend shifts out as quotient shifts in
  logic [31:0]         dvd_q;
  logic [17:0]         rem_q, dsr_q;
  logic [DivCntW-1:0]  cnt_q;

  // shared multiplier
  logic signed [31:0]  mul_a;
  logic signed [17:0]  mul_b;
  logic signed [49:0]  prod_d, prod_q;

  // output register
  logic        out_valid_q;
  logic        out_draw_q, out_last_q;
  logic [5:0]  out_map_x_q, out_map_y_q;
  logic [11:0] out_texel_q;
  logic [19:0] out_ceil_q, out_floor_q;

  // ---------------------------------------------------------------------
  // Handshake helpers
  // ---------------------------------------------------------------------
  logic [8:0]  in_row;
  logic [15:0] in_wall;
  logic [9:0]  col_cur;
  logic        out_free, in_fire, row_start, pix_fire;

  assign in_row  = s_axis_tdata[8:0];
  assign in_wall = s_axis_tdata[24:9];

  // width lowered mid-row: treat the pixel as the last of its row
  assign col_cur = ({1'b0, column_count_q} >= width_eff) ? 10'(width_eff - 11'd1)
                                                         : column_count_q;
  assign out_free  = !out_valid_q || m_axis_tready;
  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign row_start = (col_cur == 10'd0);

  // ---------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (in_fire && row_start) state_d = ST_DIV_HN;
      ST_DIV_HN:   if (cnt_q == DivLast) state_d = ST_MUL;
      ST_MUL:      state_d = ST_POST;
      ST_POST: begin
        priority if (op_q == OP_DEN)  state_d = ST_DIV_STEP;
        else if (op_q == OP_VACC)     state_d = ST_EMIT;
        else                          state_d = ST_MUL;
      end
      ST_DIV_STEP: if (cnt_q == DivLast) state_d = ST_TEX;
      ST_TEX:      state_d = ST_MUL;
      ST_EMIT:     if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // Sequencer: outputs
  // ---------------------------------------------------------------------
  always_comb begin
    s_axis_tready = 1'b0;
    pix_fire      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = out_free;
        pix_fire      = in_fire && !row_start;
      end
      ST_EMIT: pix_fire = out_free;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------
  // Divider step (restoring, one quotient bit a cycle)
  // ---------------------------------------------------------------------
  logic [18:0] rem_sh;
  logic [19:0] rem_diff;
  logic        rem_ge;

  assign rem_sh   = {rem_q, dvd_q[31]};
  assign rem_diff = {1'b0, rem_sh} - {2'b00, dsr_q};
  assign rem_ge   = !rem_diff[19];

  // ---------------------------------------------------------------------
  // Multiplier operands and post-processing
  // ---------------------------------------------------------------------
  always_comb begin
    mul_a = dist_q;
    mul_b = view_cos_q;
    unique case (op_q)
      OP_DEN:   begin mul_a = {21'd0, width_eff}; mul_b = 18'(DenScale);    end
      OP_GU:    begin mul_a = dist_q;             mul_b = view_cos_q;       end
      OP_GV:    begin mul_a = dist_q;             mul_b = view_sin_q;       end
      OP_USTEP: begin mul_a = tex_q;              mul_b = view_sin_q;       end
      OP_VSTEP: begin mul_a = tex_q;              mul_b = view_cos_q;       end
      OP_UACC:  begin mul_a = u_step_q;           mul_b = {8'd0, half_w};   end
      OP_VACC:  begin mul_a = v_step_q;           mul_b = {8'd0, half_w};   end
      default: ;
    endcase
  end

  assign prod_d = mul_a * mul_b;

  logic [49:0] prod_rnd;
  logic [31:0] fix_res;     // rounded 16.16 product, floor shift
  logic [31:0] quot_sh;     // quotient << 13, signed view

  assign prod_rnd = prod_q + 50'sh8000;
  assign fix_res  = prod_rnd[47:16];
  assign quot_sh  = 32'(dvd_q << (DistShift + TexShift));

  mul_op_e op_next;
  always_comb begin
    unique case (op_q)
      OP_DEN:   op_next = OP_GU;
      OP_GU:    op_next = OP_GV;
      OP_GV:    op_next = OP_USTEP;
      OP_USTEP: op_next = OP_VSTEP;
      OP_VSTEP: op_next = OP_UACC;
      OP_UACC:  op_next = OP_VACC;
      default:  op_next = OP_DEN;
    endcase
  end

  // ---------------------------------------------------------------------
  // Per-pixel result
  // ---------------------------------------------------------------------
  logic [8:0]  pix_row;
  logic [15:0] pix_wall;
  logic [9:0]  pix_col;
  logic [12:0] y0, wall_rows;
  logic        pix_draw, pix_last;
  logic [31:0] tu, tv;
  logic [19:0] ceil_line, floor_line;
  logic [5:0]  pix_map_x, pix_map_y;
  logic [11:0] pix_texel;
  logic [19:0] pix_ceil, pix_floor;

  always_comb begin
    if (state_q == ST_EMIT) begin
      pix_row  = row_q;
      pix_wall = wall_q;
      pix_col  = '0;
    end else begin
      pix_row  = in_row;
      pix_wall = in_wall;
      pix_col  = col_cur;
    end
  end

  // first visible row is at least one
  assign y0        = ((min_wall_q >> WallShift) == 16'd0) ? 13'd1
                                                          : 13'(min_wall_q >> WallShift);
  assign wall_rows = 13'(pix_wall >> WallShift);
  assign pix_draw  = ({4'd0, pix_row} >= y0) && ({1'b0, pix_row} < half_h) &&
                     (wall_rows <= {4'd0, pix_row});

  assign pix_map_x = 6'((u_acc_q >> 16) & 32'(MapDim - 1));
  assign pix_map_y = 6'((~(v_acc_q >> 16)) & 32'(MapDim - 1));

  assign tu = ((32'(u_acc_q[15:0]) * 32'(TexDim)) >> 16) & 32'(TexDim - 1);
  assign tv = ((32'(v_acc_q[15:0]) * 32'(TexDim)) >> 16) & 32'(TexDim - 1);
  assign pix_texel = 12'(tu * 32'(TexDim) + 32'(TexDim - 1) - tv);

  // address arithmetic wraps at 20 bits
  assign ceil_line  = 20'(half_h) - 20'(pix_row) - 20'd1;
  assign floor_line = 20'(half_h) + 20'(pix_row);
  assign pix_ceil   = 20'(ceil_line * 20'(LinePitch)) + 20'(pix_col);
  assign pix_floor  = 20'(floor_line * 20'(LinePitch)) + 20'(pix_col);

  assign pix_last = (11'(pix_col) + 11'd1) >= width_eff;

  // ---------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      op_q           <= OP_DEN;
      cnt_q          <= '0;
      column_count_q <= '0;
      u_acc_q        <= '0;
      v_acc_q        <= '0;
      u_step_q       <= '0;
      v_step_q       <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;

      unique case (state_q)
        ST_IDLE: begin
          cnt_q <= '0;
          if (in_fire && row_start) op_q <= OP_DEN;
        end
        ST_DIV_HN, ST_DIV_STEP: cnt_q <= cnt_q + 1'b1;
        ST_POST: begin
          op_q  <= op_next;
          cnt_q <= '0;
          unique case (op_q)
            OP_GU:    u_acc_q  <= {10'd0, view_x_q} + fix_res;
            OP_GV:    v_acc_q  <= fix_res - {10'd0, view_y_q};
            OP_USTEP: u_step_q <= fix_res;
            OP_VSTEP: v_step_q <= 32'd0 - fix_res;
            OP_UACC:  u_acc_q  <= u_acc_q - prod_q[31:0];
            OP_VACC:  v_acc_q  <= v_acc_q - prod_q[31:0];
            default: ;
          endcase
        end
        default: ;
      endcase

      // step u/v once per emitted pixel
      if (pix_fire) begin
        u_acc_q        <= u_acc_q + u_step_q;
        v_acc_q        <= v_acc_q + v_step_q;
        column_count_q <= pix_last ? 10'd0 : 10'(pix_col + 10'd1);
      end

      if (pix_fire)           out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------
  // Datapath registers (no reset)
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && row_start) begin
          row_q  <= in_row;
          wall_q <= in_wall;
          dvd_q  <= {1'b0, hnum_q};
          rem_q  <= '0;
          dsr_q  <= 18'(in_row) + 18'd1;
        end
      end
      ST_DIV_HN, ST_DIV_STEP: begin
        rem_q <= rem_ge ? rem_diff[17:0] : rem_sh[17:0];
        dvd_q <= {dvd_q[30:0], rem_ge};
      end
      ST_POST: begin
        if (op_q == OP_DEN) begin
          // second divide works on the magnitude, sign fixed afterwards
          dist_q <= 32'(dvd_q << DistShift);
          neg_q  <= quot_sh[31];
          dvd_q  <= quot_sh[31] ? (32'd0 - quot_sh) : quot_sh;
          rem_q  <= '0;
          dsr_q  <= prod_q[17:0];
        end
      end
      ST_TEX: tex_q <= neg_q ? (32'd0 - dvd_q) : dvd_q;
      default: ;
    endcase

    if (pix_fire) begin
      out_draw_q  <= pix_draw;
      out_map_x_q <= pix_map_x;
      out_map_y_q <= pix_map_y;
      out_texel_q <= pix_texel;
      out_ceil_q  <= pix_ceil;
      out_floor_q <= pix_floor;
      out_last_q  <= pix_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_floor_q, out_ceil_q, out_texel_q, out_map_y_q, out_map_x_q};
  assign m_axis_tuser  = out_draw_q;
  assign m_axis_tlast  = out_last_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `include "assert_macros.svh"

  `FCTAG_ASSERT(a_pix_has_room, pix_fire |-> (!out_valid_q || m_axis_tready), "result dropped")
  `FCTAG_ASSERT_NEVER(a_div_by_zero, (state_q == ST_DIV_HN || state_q == ST_DIV_STEP) && (dsr_q == 18'd0), "divisor zero")
  `FCTAG_ASSERT(a_div_runs, (state_q == ST_DIV_STEP && cnt_q != DivLast) |=> (state_q == ST_DIV_STEP), "divide cut short")
  `FCTAG_ASSERT(a_row_start_col, ($past(state_q) == ST_EMIT && state_q == ST_IDLE) |-> (column_count_q <= 10'd1), "column after row start")

endmodule
